/* rtl/rbfd_pkg.sv */
// ----------------------------------------------------------------------------
// rbfd_pkg
// Shared types and constants for the rgba box filter downscaler.
// ----------------------------------------------------------------------------
package rbfd_pkg;

   // default sizes handed to the top level parameters
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;
   localparam int CHANNELS_DEF   = 4;

   // fixed field widths
   localparam int CFG_W  = 13;
   localparam int PIX_W  = 8;
   localparam int SUM_W  = 32;
   localparam int NUM_CH = 4;
   localparam int QDEPTH = 2;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_index_type;

   // one source pixel
   typedef struct packed {
      logic [PIX_W-1:0] red_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] blue_in;
      logic [PIX_W-1:0] alpha_in;
   } req_data_type;

   // one destination pixel
   typedef struct packed {
      logic [PIX_W-1:0] red_out;
      logic [PIX_W-1:0] green_out;
      logic [PIX_W-1:0] blue_out;
      logic [PIX_W-1:0] alpha_out;
      logic             frame_end;
   } rsp_data_type;

   // finished band handed from the front end to the divider
   typedef struct packed {
      logic [NUM_CH-1:0][SUM_W-1:0] sums;
      logic [SUM_W-1:0]             count;
      logic                         frame_end;
   } job_type;

endpackage

/* rtl/rgba_box_filter_downscaler.sv */
// ----------------------------------------------------------------------------
// rgba_box_filter_downscaler
// Area-average downscaler for RGBA pixels in raster order. Each beat on the
// req side is one source pixel; each destination pixel is the truncated mean
// of its source band and comes out on the rsp side when the band's last pixel
// has been taken. Each pixel is read from the line store, then its column
// sum is written back, and req_full stays high during the write back. A
// finished band is loaded from the queue into the bit-serial divider; its
// result goes to the result register once that register is free, and
// the divider takes no new band before that. Two bands can wait in between.
// After reset and after every csr write the line store is swept to zero,
// one column a cycle, and req_full stays high until the sweep and the band
// edge divisions are done.
// ----------------------------------------------------------------------------
module rgba_box_filter_downscaler #(
   parameter int MAX_WIDTH  = rbfd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = rbfd_pkg::MAX_HEIGHT_DEF,
   parameter int CHANNELS   = rbfd_pkg::CHANNELS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  rbfd_pkg::csr_index_type    csr_index,
   input  logic [rbfd_pkg::CFG_W-1:0] csr_wdata,
   input  logic                       req_push,
   input  rbfd_pkg::req_data_type     req_data,
   output logic                       req_full,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output rbfd_pkg::rsp_data_type     rsp_data
);

   logic              q_push, q_room, q_valid, q_pop;
   rbfd_pkg::job_type q_job, q_head;

   // pixel intake and band tracking
   rbfd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .CHANNELS   (CHANNELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .q_room    (q_room),
      .q_push    (q_push),
      .q_job     (q_job)
   );

   // finished bands waiting for the divider
   rbfd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_job   (q_job),
      .q_room  (q_room),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_head  (q_head)
   );

   // averaging and result register
   rbfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/rbfd_front.sv */
// ----------------------------------------------------------------------------
// rbfd_front
// Configuration registers, band tracking and the column sum line store.
// ----------------------------------------------------------------------------
module rbfd_front #(
   parameter int MAX_WIDTH  = rbfd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = rbfd_pkg::MAX_HEIGHT_DEF,
   parameter int CHANNELS   = rbfd_pkg::CHANNELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  rbfd_pkg::csr_index_type     csr_index,
   input  logic [rbfd_pkg::CFG_W-1:0]  csr_wdata,
   input  logic                        req_push,
   input  rbfd_pkg::req_data_type      req_data,
   output logic                        req_full,
   input  logic                        q_room,
   output logic                        q_push,
   output rbfd_pkg::job_type           q_job
);

   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = $clog2(MAX_HEIGHT);
   localparam int EWX    = $clog2(MAX_WIDTH + 1);
   localparam int EWY    = $clog2(MAX_HEIGHT + 1);
   localparam int DSTEPS = (EWX > EWY) ? EWX : EWY;
   localparam int DCW    = $clog2(DSTEPS + 2);
   localparam int MEM_W  = CHANNELS * rbfd_pkg::SUM_W;
   localparam int CNT_W  = EWX + EWY;

   typedef enum logic [2:0] {
      F_CLEAR  = 3'b001,
      F_IDLE   = 3'b010,
      F_UPDATE = 3'b100
   } fstate_type;

   fstate_type state_ff, state_in;

   // configuration registers
   logic [rbfd_pkg::CFG_W-1:0] cfg_sw_ff, cfg_sh_ff, cfg_dw_ff, cfg_dh_ff;

   // clearing sweep and edge dividers
   logic [XW-1:0]  clr_ff, clr_in;
   logic           clr_done_ff, clr_done_in;
   logic [DCW-1:0] div_cnt_ff, div_cnt_in;
   logic [EWX-1:0] divc_num_ff, divc_num_in, divc_rem_ff, divc_rem_in;
   logic [EWY-1:0] divr_num_ff, divr_num_in, divr_rem_ff, divr_rem_in;

   // position and band state
   logic [XW-1:0]  src_col_ff, src_col_in, dst_col_ff, dst_col_in;
   logic [YW-1:0]  src_row_ff, src_row_in, dst_row_ff, dst_row_in;
   logic [EWX-1:0] col_start_ff, col_start_in, col_end_ff, col_end_in;
   logic [EWX-1:0] col_rem_ff, col_rem_in;
   logic [EWY-1:0] row_start_ff, row_start_in, row_end_ff, row_end_in;
   logic [EWY-1:0] row_rem_ff, row_rem_in;

   // beat held between accept and write back
   logic [rbfd_pkg::NUM_CH-1:0][rbfd_pkg::PIX_W-1:0] pix_ff, pix_in;
   logic [XW-1:0]    addr_ff, addr_in;
   logic             emit_ff, emit_in;
   logic             fend_ff, fend_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // line store
   logic [MEM_W-1:0] mem [MAX_WIDTH];
   logic [MEM_W-1:0] rd_ff;
   logic             mem_we;
   logic [XW-1:0]    mem_addr;
   logic [MEM_W-1:0] mem_wdata;

   // effective sizes
   logic [EWX-1:0] eff_sw, eff_dw;
   logic [EWY-1:0] eff_sh, eff_dh;

   // combinational helpers
   logic           accept;
   logic           col_last, row_last, src_last_col, src_last_row;
   logic [EWX:0]   divc_sh, csum;
   logic [EWY:0]   divr_sh, rsum;
   logic           divc_ge, divr_ge, cge, rge;
   logic [EWX-1:0] col_w;
   logic [EWY-1:0] row_h;
   logic [rbfd_pkg::NUM_CH-1:0][rbfd_pkg::SUM_W-1:0] new_sum;

   // saturate register values to legal sizes
   always_comb begin
      if (cfg_sw_ff == '0) begin
         eff_sw = EWX'(1);
      end else if (32'(cfg_sw_ff) > 32'(MAX_WIDTH)) begin
         eff_sw = EWX'(MAX_WIDTH);
      end else begin
         eff_sw = EWX'(cfg_sw_ff);
      end
      if (cfg_sh_ff == '0) begin
         eff_sh = EWY'(1);
      end else if (32'(cfg_sh_ff) > 32'(MAX_HEIGHT)) begin
         eff_sh = EWY'(MAX_HEIGHT);
      end else begin
         eff_sh = EWY'(cfg_sh_ff);
      end
      if (cfg_dw_ff == '0) begin
         eff_dw = EWX'(1);
      end else if (32'(cfg_dw_ff) > 32'(eff_sw)) begin
         eff_dw = eff_sw;
      end else begin
         eff_dw = EWX'(cfg_dw_ff);
      end
      if (cfg_dh_ff == '0) begin
         eff_dh = EWY'(1);
      end else if (32'(cfg_dh_ff) > 32'(eff_sh)) begin
         eff_dh = eff_sh;
      end else begin
         eff_dh = EWY'(cfg_dh_ff);
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_sw_ff <= rbfd_pkg::CFG_W'(1);
         cfg_sh_ff <= rbfd_pkg::CFG_W'(1);
         cfg_dw_ff <= rbfd_pkg::CFG_W'(1);
         cfg_dh_ff <= rbfd_pkg::CFG_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            rbfd_pkg::CSR_SRC_WIDTH:  cfg_sw_ff <= csr_wdata;
            rbfd_pkg::CSR_SRC_HEIGHT: cfg_sh_ff <= csr_wdata;
            rbfd_pkg::CSR_DST_WIDTH:  cfg_dw_ff <= csr_wdata;
            rbfd_pkg::CSR_DST_HEIGHT: cfg_dh_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign accept   = (state_ff == F_IDLE) && q_room && req_push;
   assign req_full = !((state_ff == F_IDLE) && q_room);

   // band classification of the current position
   assign col_last     = (EWX'(src_col_ff) + EWX'(1)) >= col_end_ff;
   assign row_last     = (EWY'(src_row_ff) + EWY'(1)) >= row_end_ff;
   assign src_last_col = (EWX'(src_col_ff) + EWX'(1)) >= eff_sw;
   assign src_last_row = (EWY'(src_row_ff) + EWY'(1)) >= eff_sh;
   assign col_w        = col_end_ff - col_start_ff;
   assign row_h        = row_end_ff - row_start_ff;

   // restoring division steps for the band edge increments
   assign divc_sh = {divc_rem_ff, divc_num_ff[EWX-1]};
   assign divc_ge = divc_sh >= {1'b0, eff_dw};
   assign divr_sh = {divr_rem_ff, divr_num_ff[EWY-1]};
   assign divr_ge = divr_sh >= {1'b0, eff_dh};

   // next band edge: add quotient, carry the remainder
   assign csum = {1'b0, col_rem_ff} + {1'b0, divc_rem_ff};
   assign cge  = csum >= {1'b0, eff_dw};
   assign rsum = {1'b0, row_rem_ff} + {1'b0, divr_rem_ff};
   assign rge  = rsum >= {1'b0, eff_dh};

   // accumulated sums for the held beat
   always_comb begin
      for (int c = 0; c < rbfd_pkg::NUM_CH; c++) begin
         if (c < CHANNELS) begin
            new_sum[c] = rd_ff[c*rbfd_pkg::SUM_W +: rbfd_pkg::SUM_W]
                         + rbfd_pkg::SUM_W'(pix_ff[c]);
         end else begin
            new_sum[c] = '0;
         end
      end
   end

   // line store port
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = dst_col_ff;
      mem_wdata = '0;
      case (state_ff)
         F_CLEAR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
         end
         F_UPDATE: begin
            mem_we   = 1'b1;
            mem_addr = addr_ff;
            for (int c = 0; c < CHANNELS; c++) begin
               mem_wdata[c*rbfd_pkg::SUM_W +: rbfd_pkg::SUM_W] =
                  emit_ff ? '0 : new_sum[c];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      rd_ff <= mem[mem_addr];
   end

   // finished band to the queue
   assign q_push          = (state_ff == F_UPDATE) && emit_ff;
   assign q_job.sums      = new_sum;
   assign q_job.count     = rbfd_pkg::SUM_W'(count_ff);
   assign q_job.frame_end = fend_ff;

   // control next state
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      clr_done_in  = clr_done_ff;
      div_cnt_in   = div_cnt_ff;
      divc_num_in  = divc_num_ff;
      divc_rem_in  = divc_rem_ff;
      divr_num_in  = divr_num_ff;
      divr_rem_in  = divr_rem_ff;
      src_col_in   = src_col_ff;
      dst_col_in   = dst_col_ff;
      src_row_in   = src_row_ff;
      dst_row_in   = dst_row_ff;
      col_start_in = col_start_ff;
      col_end_in   = col_end_ff;
      col_rem_in   = col_rem_ff;
      row_start_in = row_start_ff;
      row_end_in   = row_end_ff;
      row_rem_in   = row_rem_ff;
      pix_in       = pix_ff;
      addr_in      = addr_ff;
      emit_in      = emit_ff;
      fend_in      = fend_ff;
      count_in     = count_ff;

      case (state_ff)
         F_CLEAR: begin
            // zero sweep over the line store
            if (!clr_done_ff) begin
               if (clr_ff == XW'(MAX_WIDTH - 1)) begin
                  clr_done_in = 1'b1;
               end else begin
                  clr_in = clr_ff + XW'(1);
               end
            end
            // edge dividers: load, then one quotient bit a cycle
            if (div_cnt_ff == '0) begin
               divc_num_in = eff_sw;
               divc_rem_in = '0;
               divr_num_in = eff_sh;
               divr_rem_in = '0;
            end else begin
               if (div_cnt_ff <= DCW'(EWX)) begin
                  divc_num_in = {divc_num_ff[EWX-2:0], divc_ge};
                  divc_rem_in = divc_ge ? EWX'(divc_sh - {1'b0, eff_dw})
                                        : EWX'(divc_sh);
               end
               if (div_cnt_ff <= DCW'(EWY)) begin
                  divr_num_in = {divr_num_ff[EWY-2:0], divr_ge};
                  divr_rem_in = divr_ge ? EWY'(divr_sh - {1'b0, eff_dh})
                                        : EWY'(divr_sh);
               end
            end
            if (div_cnt_ff != DCW'(DSTEPS + 1)) begin
               div_cnt_in = div_cnt_ff + DCW'(1);
            end
            // start of frame
            if (clr_done_ff && div_cnt_ff == DCW'(DSTEPS + 1)) begin
               state_in     = F_IDLE;
               src_col_in   = '0;
               dst_col_in   = '0;
               src_row_in   = '0;
               dst_row_in   = '0;
               col_start_in = '0;
               col_end_in   = divc_num_ff;
               col_rem_in   = divc_rem_ff;
               row_start_in = '0;
               row_end_in   = divr_num_ff;
               row_rem_in   = divr_rem_ff;
            end
         end

         F_IDLE: begin
            if (accept) begin
               state_in = F_UPDATE;
               pix_in   = {req_data.alpha_in, req_data.blue_in,
                           req_data.green_in, req_data.red_in};
               addr_in  = dst_col_ff;
               emit_in  = col_last && row_last;
               fend_in  = ((EWX'(dst_col_ff) + EWX'(1)) >= eff_dw) &&
                          ((EWY'(dst_row_ff) + EWY'(1)) >= eff_dh);
               count_in = CNT_W'(col_w) * CNT_W'(row_h);
               // advance the raster position
               if (src_last_col) begin
                  src_col_in   = '0;
                  dst_col_in   = '0;
                  col_start_in = '0;
                  col_end_in   = divc_num_ff;
                  col_rem_in   = divc_rem_ff;
                  if (src_last_row) begin
                     src_row_in   = '0;
                     dst_row_in   = '0;
                     row_start_in = '0;
                     row_end_in   = divr_num_ff;
                     row_rem_in   = divr_rem_ff;
                  end else begin
                     src_row_in = src_row_ff + YW'(1);
                     if (row_last) begin
                        dst_row_in   = dst_row_ff + YW'(1);
                        row_start_in = row_end_ff;
                        row_end_in   = row_end_ff + divr_num_ff + EWY'(rge);
                        row_rem_in   = rge ? EWY'(rsum - {1'b0, eff_dh})
                                           : EWY'(rsum);
                     end
                  end
               end else begin
                  src_col_in = src_col_ff + XW'(1);
                  if (col_last) begin
                     dst_col_in   = dst_col_ff + XW'(1);
                     col_start_in = col_end_ff;
                     col_end_in   = col_end_ff + divc_num_ff + EWX'(cge);
                     col_rem_in   = cge ? EWX'(csum - {1'b0, eff_dw})
                                        : EWX'(csum);
                  end
               end
            end
         end

         F_UPDATE: begin
            state_in = F_IDLE;
         end

         default: begin
            state_in = F_CLEAR;
         end
      endcase

      // any register write restarts the frame
      if (csr_we) begin
         state_in    = F_CLEAR;
         clr_in      = '0;
         clr_done_in = 1'b0;
         div_cnt_in  = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_CLEAR;
         clr_ff      <= '0;
         clr_done_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         clr_done_ff <= clr_done_in;
         div_cnt_ff  <= div_cnt_in;
      end
   end

   // position, divider and held beat registers
   always_ff @(posedge clock) begin
      divc_num_ff  <= divc_num_in;
      divc_rem_ff  <= divc_rem_in;
      divr_num_ff  <= divr_num_in;
      divr_rem_ff  <= divr_rem_in;
      src_col_ff   <= src_col_in;
      dst_col_ff   <= dst_col_in;
      src_row_ff   <= src_row_in;
      dst_row_ff   <= dst_row_in;
      col_start_ff <= col_start_in;
      col_end_ff   <= col_end_in;
      col_rem_ff   <= col_rem_in;
      row_start_ff <= row_start_in;
      row_end_ff   <= row_end_in;
      row_rem_ff   <= row_rem_in;
      pix_ff       <= pix_in;
      addr_ff      <= addr_in;
      emit_ff      <= emit_in;
      fend_ff      <= fend_in;
      count_ff     <= count_in;
   end

endmodule

/* rtl/rbfd_queue.sv */
// ----------------------------------------------------------------------------
// rbfd_queue
// Short queue of finished bands between the front end and the divider.
// ----------------------------------------------------------------------------
module rbfd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_push,
   input  rbfd_pkg::job_type q_job,
   output logic              q_room,
   output logic              q_valid,
   input  logic              q_pop,
   output rbfd_pkg::job_type q_head
);

   localparam int PW = (rbfd_pkg::QDEPTH > 1) ? $clog2(rbfd_pkg::QDEPTH) : 1;
   localparam int CW = $clog2(rbfd_pkg::QDEPTH + 1);

   rbfd_pkg::job_type slot_ff [rbfd_pkg::QDEPTH];
   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_pop;

   assign q_room  = cnt_ff < CW'(rbfd_pkg::QDEPTH);
   assign q_valid = cnt_ff != '0;
   assign q_head  = slot_ff[rd_ff];
   assign do_pop  = q_pop && q_valid;

   // pointer and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (q_push) begin
         wr_in = (wr_ff == PW'(rbfd_pkg::QDEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(rbfd_pkg::QDEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (q_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (!q_push && do_pop) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (q_push) begin
         slot_ff[wr_ff] <= q_job;
      end
   end

endmodule

/* rtl/rbfd_back.sv */
// ----------------------------------------------------------------------------
// rbfd_back
// Bit-serial divider of the four channel sums and the result register.
// ----------------------------------------------------------------------------
module rbfd_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  rbfd_pkg::job_type      q_head,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output rbfd_pkg::rsp_data_type rsp_data
);

   localparam int SW = rbfd_pkg::SUM_W;
   localparam int NC = rbfd_pkg::NUM_CH;
   localparam int KW = $clog2(SW);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_RUN  = 3'b010,
      B_HOLD = 3'b100
   } bstate_type;

   bstate_type state_ff, state_in;
   logic [KW-1:0] step_ff, step_in;
   logic [NC-1:0][SW-1:0] num_ff, num_in, rem_ff, rem_in;
   logic [SW-1:0] den_ff, den_in;
   logic          fend_ff, fend_in;
   logic          valid_ff, valid_in;
   rbfd_pkg::rsp_data_type out_ff, out_in;
   logic [SW:0]   shifted [NC];
   logic          load_out;

   assign rsp_empty = !valid_ff;
   assign rsp_data  = out_ff;
   assign q_pop     = (state_ff == B_IDLE) && q_valid;
   assign load_out  = (state_ff == B_HOLD) && (!valid_ff || rsp_pop);

   // one quotient bit per channel each cycle
   always_comb begin
      for (int c = 0; c < NC; c++) begin
         shifted[c] = {rem_ff[c], num_ff[c][SW-1]};
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      fend_in  = fend_ff;
      valid_in = valid_ff;
      out_in   = out_ff;

      if (rsp_pop && valid_ff) begin
         valid_in = 1'b0;
      end

      case (state_ff)
         B_IDLE: begin
            if (q_valid) begin
               state_in = B_RUN;
               step_in  = '0;
               num_in   = q_head.sums;
               rem_in   = '0;
               den_in   = q_head.count;
               fend_in  = q_head.frame_end;
            end
         end
         B_RUN: begin
            for (int c = 0; c < NC; c++) begin
               if (shifted[c] >= {1'b0, den_ff}) begin
                  rem_in[c] = SW'(shifted[c] - {1'b0, den_ff});
                  num_in[c] = {num_ff[c][SW-2:0], 1'b1};
               end else begin
                  rem_in[c] = SW'(shifted[c]);
                  num_in[c] = {num_ff[c][SW-2:0], 1'b0};
               end
            end
            step_in = step_ff + KW'(1);
            if (step_ff == KW'(SW - 1)) begin
               state_in = B_HOLD;
            end
         end
         B_HOLD: begin
            if (load_out) begin
               state_in         = B_IDLE;
               valid_in         = 1'b1;
               out_in.red_out   = num_ff[0][rbfd_pkg::PIX_W-1:0];
               out_in.green_out = num_ff[1][rbfd_pkg::PIX_W-1:0];
               out_in.blue_out  = num_ff[2][rbfd_pkg::PIX_W-1:0];
               out_in.alpha_out = num_ff[3][rbfd_pkg::PIX_W-1:0];
               out_in.frame_end = fend_ff;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      fend_ff <= fend_in;
      out_ff  <= out_in;
   end

endmodule

/* rtl/rbfd_checker.sv */
// ----------------------------------------------------------------------------
// rbfd_checker
// Port-level checks for the downscaler, bound to the top level.
// ----------------------------------------------------------------------------
module rbfd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       csr_we,
   input logic                       req_full,
   input logic                       rsp_empty,
   input logic                       rsp_pop,
   input rbfd_pkg::rsp_data_type     rsp_data
);

   // reset starts the clearing sweep, no pixel taken
   a_reset_full: assert property (@(posedge clock) reset |=> req_full)
      else $error("req_full low right after reset");

   // a register write restarts the frame and blocks intake
   a_csr_full: assert property (@(posedge clock) csr_we |=> req_full)
      else $error("req_full low right after csr write");

   // no result survives reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending right after reset");

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting result changed before pop");

endmodule

bind rgba_box_filter_downscaler rbfd_checker u_rbfd_checker (.*);
